// ----- hw/rtl/rqs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared constants and the controller state type for the record sorter.
// ----------------------------------------------------------------------------
package rqs_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = 7;
    localparam int TAG_W       = 16;
    localparam int KEY_W       = 16;
    localparam int REC_W       = TAG_W + KEY_W;
    localparam int STACK_SLOTS = 64;
    localparam int STK_AW      = $clog2(STACK_SLOTS);
    localparam int STK_W       = 2 * CNT_W;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_POP,
        ST_RANGE,
        ST_SW_A,
        ST_SW_B,
        ST_SW_C,
        ST_CHK_R,
        ST_CHK_L,
        ST_SWP,
        ST_FIN_RD,
        ST_FIN_A,
        ST_FIN_B,
        ST_PUSH_HI,
        ST_PUSH_LO,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WT
    } rqs_state_t;

endpackage

// ----- hw/rtl/rqs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/record_quicksort_by_key.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_quicksort_by_key
// Collects tagged records, sorts them by ascending key with a middle-pivot
// quicksort driven by an explicit range stack, and streams them out in order.
//
//   Channel | Direction | Payload                                  | Flow
//   s_      | in        | s_rec_tag, s_sort_key, s_final_item      | valid/ready
//   m_      | out       | m_out_tag, m_out_key, m_end_of_set       | valid/ready
//
// Loading accepts one input beat per cycle until the final beat.
// Sorting runs on the record RAM through its single read and single write
// port, stepping the pointers one at a time, swapping records and, per range,
// doing pivot setup, pivot placement and the two stack pushes.
// Output holds each result beat until the sink takes it, then loads the next.
// Reset is synchronous and active low; the RAMs need no clearing pass.
// Input is refused from the final beat until the last result beat is taken.
// ----------------------------------------------------------------------------
module record_quicksort_by_key
    import rqs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [TAG_W-1:0] s_rec_tag,
    input  logic [KEY_W-1:0] s_sort_key,
    input  logic             s_final_item,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [TAG_W-1:0] m_out_tag,
    output logic [KEY_W-1:0] m_out_key,
    output logic             m_end_of_set
);

    rqs_state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] l_reg, l_next;
    logic [CNT_W-1:0] rp1_reg, rp1_next;
    logic [REC_W-1:0] piv_reg, piv_next;
    logic [REC_W-1:0] recr_reg, recr_next;
    logic             m_valid_reg, m_valid_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             eos_reg, eos_next;

    logic              rec_we;
    logic [ADDR_W-1:0] rec_waddr, rec_raddr;
    logic [REC_W-1:0]  rec_wdata, rec_rdata;
    logic              stk_we;
    logic [STK_AW-1:0] stk_waddr, stk_raddr;
    logic [STK_W-1:0]  stk_wdata, stk_rdata;

    logic [CNT_W-1:0] a_l, a_r, a_last, a_mid;
    logic [CNT_W-1:0] e_s, e_n, e_mid;
    logic [CNT_W:0]   e_end;
    logic [KEY_W-1:0] key_rd, key_piv;
    logic [CNT_W-1:0] hi_s, hi_n;

    rqs_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    rqs_ram #(.WIDTH(STK_W), .DEPTH(STACK_SLOTS)) u_stk_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign a_l     = s_reg + l_reg;
    assign a_r     = s_reg + rp1_reg - CNT_W'(1);
    assign a_last  = s_reg + n_reg - CNT_W'(1);
    assign a_mid   = s_reg + {1'b0, n_reg[CNT_W-1:1]};
    assign e_s     = stk_rdata[STK_W-1:CNT_W];
    assign e_n     = stk_rdata[CNT_W-1:0];
    assign e_mid   = e_s + {1'b0, e_n[CNT_W-1:1]};
    assign e_end   = {1'b0, e_s} + {1'b0, e_n};
    assign key_rd  = rec_rdata[KEY_W-1:0];
    assign key_piv = piv_reg[KEY_W-1:0];
    assign hi_s    = s_reg + l_reg;
    assign hi_n    = n_reg - l_reg;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_out_tag    = tag_reg;
    assign m_out_key    = key_reg;
    assign m_end_of_set = eos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            depth_reg   <= '0;
            l_reg       <= '0;
            rp1_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            depth_reg   <= depth_next;
            l_reg       <= l_next;
            rp1_reg     <= rp1_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg    <= s_next;
        n_reg    <= n_next;
        piv_reg  <= piv_next;
        recr_reg <= recr_next;
        tag_reg  <= tag_next;
        key_reg  <= key_next;
        eos_reg  <= eos_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        depth_next   = depth_reg;
        s_next       = s_reg;
        n_next       = n_reg;
        l_next       = l_reg;
        rp1_next     = rp1_reg;
        piv_next     = piv_reg;
        recr_next    = recr_reg;
        m_valid_next = m_valid_reg;
        tag_next     = tag_reg;
        key_next     = key_reg;
        eos_next     = eos_reg;
        rec_we       = 1'b0;
        rec_waddr    = a_l[ADDR_W-1:0];
        rec_wdata    = piv_reg;
        rec_raddr    = a_l[ADDR_W-1:0];
        stk_we       = 1'b0;
        stk_waddr    = depth_reg[STK_AW-1:0];
        stk_wdata    = {s_reg, l_reg};
        stk_raddr    = STK_AW'(depth_reg - CNT_W'(1));

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (count_reg < CNT_W'(MAX_RECORDS)) begin
                        rec_we     = 1'b1;
                        rec_waddr  = count_reg[ADDR_W-1:0];
                        rec_wdata  = {s_rec_tag, s_sort_key};
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_final_item) begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                if (count_reg >= CNT_W'(2)) begin
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = {CNT_W'(0), count_reg};
                    depth_next = CNT_W'(1);
                    state_next = ST_POP;
                end else begin
                    l_next     = '0;
                    state_next = ST_OUT_RD;
                end
            end
            ST_POP: begin
                if (depth_reg == '0) begin
                    l_next     = '0;
                    state_next = ST_OUT_RD;
                end else begin
                    depth_next = depth_reg - CNT_W'(1);
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                if (e_n < CNT_W'(2) || e_end > {1'b0, count_reg}) begin
                    state_next = ST_POP;
                end else begin
                    s_next     = e_s;
                    n_next     = e_n;
                    rec_raddr  = e_mid[ADDR_W-1:0];
                    state_next = ST_SW_A;
                end
            end
            ST_SW_A: begin
                piv_next   = rec_rdata;
                rec_raddr  = a_last[ADDR_W-1:0];
                state_next = ST_SW_B;
            end
            ST_SW_B: begin
                rec_we     = 1'b1;
                rec_waddr  = a_mid[ADDR_W-1:0];
                rec_wdata  = rec_rdata;
                state_next = ST_SW_C;
            end
            ST_SW_C: begin
                rec_we     = 1'b1;
                rec_waddr  = a_last[ADDR_W-1:0];
                rec_wdata  = piv_reg;
                l_next     = '0;
                rp1_next   = n_reg - CNT_W'(1);
                rec_raddr  = ADDR_W'(a_last - CNT_W'(1));
                state_next = ST_CHK_R;
            end
            ST_CHK_R: begin
                if (key_rd > key_piv) begin
                    rp1_next = rp1_reg - CNT_W'(1);
                    if (l_reg >= rp1_reg - CNT_W'(1)) begin
                        state_next = ST_FIN_RD;
                    end else begin
                        rec_raddr = ADDR_W'(a_r - CNT_W'(1));
                    end
                end else begin
                    recr_next  = rec_rdata;
                    rec_raddr  = a_l[ADDR_W-1:0];
                    state_next = ST_CHK_L;
                end
            end
            ST_CHK_L: begin
                if (key_rd <= key_piv) begin
                    l_next = l_reg + CNT_W'(1);
                    if (l_reg + CNT_W'(1) >= rp1_reg) begin
                        state_next = ST_FIN_RD;
                    end else begin
                        rec_raddr = ADDR_W'(a_l + CNT_W'(1));
                    end
                end else begin
                    rec_we     = 1'b1;
                    rec_waddr  = a_r[ADDR_W-1:0];
                    rec_wdata  = rec_rdata;
                    state_next = ST_SWP;
                end
            end
            ST_SWP: begin
                rec_we    = 1'b1;
                rec_waddr = a_l[ADDR_W-1:0];
                rec_wdata = recr_reg;
                l_next    = l_reg + CNT_W'(1);
                if (l_reg + CNT_W'(1) >= rp1_reg) begin
                    state_next = ST_FIN_RD;
                end else begin
                    rec_raddr  = a_r[ADDR_W-1:0];
                    state_next = ST_CHK_R;
                end
            end
            ST_FIN_RD: begin
                rec_raddr  = a_l[ADDR_W-1:0];
                state_next = ST_FIN_A;
            end
            ST_FIN_A: begin
                rec_we     = 1'b1;
                rec_waddr  = a_last[ADDR_W-1:0];
                rec_wdata  = rec_rdata;
                state_next = ST_FIN_B;
            end
            ST_FIN_B: begin
                rec_we     = 1'b1;
                rec_waddr  = a_l[ADDR_W-1:0];
                rec_wdata  = piv_reg;
                state_next = ST_PUSH_HI;
            end
            ST_PUSH_HI: begin
                if (hi_n >= CNT_W'(2) && depth_reg < CNT_W'(STACK_SLOTS)) begin
                    stk_we     = 1'b1;
                    stk_wdata  = {hi_s, hi_n};
                    depth_next = depth_reg + CNT_W'(1);
                end
                state_next = ST_PUSH_LO;
            end
            ST_PUSH_LO: begin
                if (l_reg >= CNT_W'(2) && depth_reg < CNT_W'(STACK_SLOTS)) begin
                    stk_we     = 1'b1;
                    stk_wdata  = {s_reg, l_reg};
                    depth_next = depth_reg + CNT_W'(1);
                end
                state_next = ST_POP;
            end
            ST_OUT_RD: begin
                rec_raddr  = l_reg[ADDR_W-1:0];
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                m_valid_next = 1'b1;
                tag_next     = rec_rdata[REC_W-1:KEY_W];
                key_next     = rec_rdata[KEY_W-1:0];
                eos_next     = (l_reg + CNT_W'(1) == count_reg);
                state_next   = ST_OUT_WT;
            end
            ST_OUT_WT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (eos_reg) begin
                        count_next = '0;
                        depth_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        l_next     = l_reg + CNT_W'(1);
                        rec_raddr  = ADDR_W'(l_reg + CNT_W'(1));
                        state_next = ST_OUT_LD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count exceeds the store");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CNT_W'(STACK_SLOTS))
        else $error("range stack overflow");

    a_ptr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK_R || state_reg == ST_CHK_L) |-> (l_reg < rp1_reg))
        else $error("partition pointers crossed during a scan");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid_reg))
        else $error("input accepted while a result beat is pending");

    a_set_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && eos_reg) |=> (count_reg == '0))
        else $error("store not emptied after the last result beat");

endmodule
